### rtl/dwls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwls_pkg
// Shared types and codes for the double-ended queue with linear search.
// ----------------------------------------------------------------------------
package dwls_pkg;

  localparam int unsigned DataW = 32;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_SEARCH     = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SHIFT_R,
    OP_SHIFT_L,
    OP_PUSH_BACK,
    OP_POP_BACK
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [DataW-1:0] value;
  } cell_ctrl_t;

  // Search word that travels down the chain, one cell per cycle.
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [DataW-1:0] key;
  } srch_t;

endpackage

### rtl/deque_with_linear_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_linear_search
// Bounded double-ended queue of signed 32-bit values held in a chain of cells,
// with a search for the first matching entry counted from the front.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                   Word
//  in       input      in_valid_i / in_ready_o     command_i, value_i
//  out      output     out_valid_o / out_ready_i   status_o, found_o,
//                                                  position_o, entry_count_o
//
// Pushes, pops and unknown commands need no wait state; the result word is
// loaded into the output register at the edge that accepts the command.
// A search moves the search word down the chain one cell per cycle; the result
// is then held in ST_DONE until the output register is free.
// The front entry always sits in cell 0. Reset clears the occupied flags and
// the count; entry data is not reset. A stalled output blocks new commands.
// ----------------------------------------------------------------------------
module deque_with_linear_search
  import dwls_pkg::*;
#(
  parameter  int unsigned CAPACITY = 16,
  localparam int unsigned CW       = $clog2(CAPACITY + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [2:0]              command_i,
  input  logic signed [DataW-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [1:0]              status_o,
  output logic                    found_o,
  output logic [CW-1:0]           position_o,
  output logic [CW-1:0]           entry_count_o
);

  localparam logic [CW-1:0] Cap = CW'(CAPACITY);

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          out_valid_q, out_valid_d;
  logic [1:0]    status_q, status_d;
  logic          found_q, found_d;
  logic [CW-1:0] pos_q, pos_d;
  logic          res_found_q, res_found_d;
  logic [CW-1:0] res_pos_q, res_pos_d;

  cell_ctrl_t    ctrl;
  srch_t         srch_in;
  logic          accept;
  logic          out_free;
  logic          is_full, is_empty;

  logic [DataW-1:0] cell_data [CAPACITY];
  logic             cell_occ  [CAPACITY];
  srch_t            cell_srch [CAPACITY];
  logic [CW-1:0]    cell_pos  [CAPACITY];

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign is_full    = (count_q == Cap);
  assign is_empty   = (count_q == '0);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    found_d     = found_q;
    pos_d       = pos_q;
    res_found_d = res_found_q;
    res_pos_d   = res_pos_q;
    ctrl.op     = OP_HOLD;
    ctrl.value  = value_i;
    srch_in.valid = 1'b0;
    srch_in.found = 1'b0;
    srch_in.key   = value_i;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          status_d    = STATUS_OK;
          found_d     = 1'b0;
          pos_d       = '0;
          out_valid_d = 1'b1;
          case (command_i)
            CMD_PUSH_FRONT: begin
              if (is_full) begin
                status_d = STATUS_FULL;
              end else begin
                ctrl.op = OP_SHIFT_R;
                count_d = count_q + 1'b1;
              end
            end
            CMD_PUSH_BACK: begin
              if (is_full) begin
                status_d = STATUS_FULL;
              end else begin
                ctrl.op = OP_PUSH_BACK;
                count_d = count_q + 1'b1;
              end
            end
            CMD_POP_FRONT: begin
              if (is_empty) begin
                status_d = STATUS_EMPTY;
              end else begin
                ctrl.op = OP_SHIFT_L;
                count_d = count_q - 1'b1;
              end
            end
            CMD_POP_BACK: begin
              if (is_empty) begin
                status_d = STATUS_EMPTY;
              end else begin
                ctrl.op = OP_POP_BACK;
                count_d = count_q - 1'b1;
              end
            end
            CMD_SEARCH: begin
              srch_in.valid = 1'b1;
              out_valid_d   = out_valid_q && !out_ready_i;
              state_d       = ST_SEARCH;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SEARCH: begin
        if (cell_srch[CAPACITY-1].valid) begin
          res_found_d = cell_srch[CAPACITY-1].found;
          res_pos_d   = cell_pos[CAPACITY-1];
          state_d     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          status_d    = STATUS_OK;
          found_d     = res_found_q;
          pos_d       = res_pos_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q    <= status_d;
    found_q     <= found_d;
    pos_q       <= pos_d;
    res_found_q <= res_found_d;
    res_pos_q   <= res_pos_d;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DataW-1:0] left_data, right_data;
    logic             left_occ, right_occ;
    srch_t            srch_up;
    logic [CW-1:0]    pos_up;

    if (g == 0) begin : g_head
      // The head cell sees the new entry and an occupied left neighbor.
      assign left_data = value_i;
      assign left_occ  = 1'b1;
      assign srch_up   = srch_in;
      assign pos_up    = '0;
    end else begin : g_body
      assign left_data = cell_data[g-1];
      assign left_occ  = cell_occ[g-1];
      assign srch_up   = cell_srch[g-1];
      assign pos_up    = cell_pos[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right_data = '0;
      assign right_occ  = 1'b0;
    end else begin : g_inner
      assign right_data = cell_data[g+1];
      assign right_occ  = cell_occ[g+1];
    end

    dwls_cell #(
      .CW  (CW),
      .IDX (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .left_data_i  (left_data),
      .left_occ_i   (left_occ),
      .right_data_i (right_data),
      .right_occ_i  (right_occ),
      .srch_i       (srch_up),
      .pos_i        (pos_up),
      .data_o       (cell_data[g]),
      .occ_o        (cell_occ[g]),
      .srch_o       (cell_srch[g]),
      .pos_o        (cell_pos[g])
    );
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_o       = found_q;
  assign position_o    = pos_q;
  assign entry_count_o = count_q;

endmodule

### rtl/dwls_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwls_cell
// One slot of the queue: holds an entry and its occupied flag, shifts with its
// neighbors, and compares the passing search word against its entry.
// ----------------------------------------------------------------------------
module dwls_cell
  import dwls_pkg::*;
#(
  parameter int unsigned CW  = 5,
  parameter int unsigned IDX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  logic [DataW-1:0] left_data_i,
  input  logic             left_occ_i,
  input  logic [DataW-1:0] right_data_i,
  input  logic             right_occ_i,
  input  srch_t            srch_i,
  input  logic [CW-1:0]    pos_i,
  output logic [DataW-1:0] data_o,
  output logic             occ_o,
  output srch_t            srch_o,
  output logic [CW-1:0]    pos_o
);

  localparam logic [CW-1:0] MyPos = CW'(IDX + 1);

  logic [DataW-1:0] data_q, data_d;
  logic             occ_q, occ_d;
  srch_t            srch_q, srch_d;
  logic [CW-1:0]    pos_q, pos_d;
  logic             match;

  always_comb begin
    data_d = data_q;
    occ_d  = occ_q;
    case (ctrl_i.op)
      OP_SHIFT_R: begin
        data_d = left_data_i;
        occ_d  = left_occ_i;
      end
      OP_SHIFT_L: begin
        data_d = right_data_i;
        occ_d  = right_occ_i;
      end
      OP_PUSH_BACK: begin
        // The first free cell after the occupied run takes the new entry.
        if (!occ_q && left_occ_i) begin
          data_d = ctrl_i.value;
          occ_d  = 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (occ_q && !right_occ_i) begin
          occ_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign match = occ_q && (data_q == srch_i.key);

  always_comb begin
    srch_d.valid = srch_i.valid;
    srch_d.key   = srch_i.key;
    srch_d.found = srch_i.found || match;
    if (srch_i.found) begin
      pos_d = pos_i;
    end else if (match) begin
      pos_d = MyPos;
    end else begin
      pos_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= 1'b0;
      srch_q <= '0;
    end else begin
      occ_q  <= occ_d;
      srch_q <= srch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    pos_q  <= pos_d;
  end

  assign data_o = data_q;
  assign occ_o  = occ_q;
  assign srch_o = srch_q;
  assign pos_o  = pos_q;

endmodule
